// ===== rtl/core/i2cm_pkg.sv =====
// Shared constants, types and helpers of the I2C master bit engine.
package i2cm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BYTE_W        = BITS_PER_BYTE;
   localparam int BIT_SEL_W     = $clog2(BITS_PER_BYTE);
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE + 1);
   localparam int OPCODE_W      = 3;
   localparam int HALF_W        = 16;
   localparam int PHASE_W       = 2;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd90;

   localparam logic [OPCODE_W-1:0] OP_NOP   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_START = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_RACK  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SACK  = 3'd6;

   localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;

   typedef enum logic [6:0] {
      CMD_IDLE  = 7'b0000001,
      CMD_START = 7'b0000010,
      CMD_STOP  = 7'b0000100,
      CMD_WRITE = 7'b0001000,
      CMD_READ  = 7'b0010000,
      CMD_RACK  = 7'b0100000,
      CMD_SACK  = 7'b1000000
   } cmd_state_type;

   typedef struct packed {
      cmd_state_type        cmd;
      logic [PHASE_W-1:0]   phase;
      logic [BIT_IDX_W-1:0] bit_index;
      logic [BYTE_W-1:0]    shift;
      logic [HALF_W-1:0]    tick;
      logic                 scl;
      logic                 sda;
      logic                 ack;
      logic [BYTE_W-1:0]    rx;
   } engine_state_type;

   function automatic logic [HALF_W-1:0] seg_len(input logic [HALF_W-1:0] half);
      return (half == '0) ? HALF_W'(1) : half;
   endfunction

endpackage

// ===== rtl/core/i2cm_req_if.sv =====
// Command channel: opcode, transmit byte and sampled SDA level per tick.
interface i2cm_req_if;
   logic                                valid;
   logic                                ready;
   logic [i2cm_pkg::OPCODE_W-1:0]       opcode;
   logic [i2cm_pkg::BYTE_W-1:0]         tx_byte;
   logic                                sda_in;

   modport source (output valid, output opcode, output tx_byte, output sda_in, input ready);
   modport sink   (input valid, input opcode, input tx_byte, input sda_in, output ready);
endinterface

// ===== rtl/core/i2cm_rsp_if.sv =====
// Result channel: bus drive levels and status per tick.
interface i2cm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          scl_out;
   logic                          sda_out;
   logic                          busy_res;
   logic                          done_res;
   logic [i2cm_pkg::BYTE_W-1:0]   rx_byte;
   logic                          ack_bit;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output rx_byte, output ack_bit, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                   input done_res, input rx_byte, input ack_bit, output ready);
endinterface

// ===== rtl/core/i2cm_step.sv =====
// Next-state logic of the engine for one bus tick.
module i2cm_step (
   input  i2cm_pkg::engine_state_type          cur,
   input  logic [i2cm_pkg::OPCODE_W-1:0]       opcode,
   input  logic [i2cm_pkg::BYTE_W-1:0]         tx_byte,
   input  logic                                sda_in,
   input  logic [i2cm_pkg::HALF_W-1:0]         half_period,
   output i2cm_pkg::engine_state_type          nxt,
   output logic                                done
);

   i2cm_pkg::cmd_state_type                 cmd_sel;
   logic                                    load;
   logic                                    fin;
   logic [i2cm_pkg::HALF_W-1:0]             tick_dec;
   logic [i2cm_pkg::BIT_IDX_W-1:0]          bit_inc;
   logic [i2cm_pkg::BIT_SEL_W-1:0]          sel;

   assign bit_inc = cur.bit_index + i2cm_pkg::BIT_IDX_W'(1);

   always_comb begin
      unique case (opcode)
         i2cm_pkg::OP_NOP:   cmd_sel = i2cm_pkg::CMD_IDLE;
         i2cm_pkg::OP_START: cmd_sel = i2cm_pkg::CMD_START;
         i2cm_pkg::OP_STOP:  cmd_sel = i2cm_pkg::CMD_STOP;
         i2cm_pkg::OP_WRITE: cmd_sel = i2cm_pkg::CMD_WRITE;
         i2cm_pkg::OP_READ:  cmd_sel = i2cm_pkg::CMD_READ;
         i2cm_pkg::OP_RACK:  cmd_sel = i2cm_pkg::CMD_RACK;
         i2cm_pkg::OP_SACK:  cmd_sel = i2cm_pkg::CMD_SACK;
         default:            cmd_sel = i2cm_pkg::CMD_IDLE;
      endcase
   end

   always_comb begin
      nxt      = cur;
      load     = 1'b0;
      fin      = 1'b0;
      tick_dec = cur.tick;
      done     = 1'b0;
      sel      = '0;

      if (cur.cmd == i2cm_pkg::CMD_IDLE) begin
         if (cmd_sel != i2cm_pkg::CMD_IDLE) begin
            nxt.cmd       = cmd_sel;
            nxt.phase     = i2cm_pkg::PHASE_FIRST;
            nxt.bit_index = '0;
            load          = 1'b1;
            if (cmd_sel == i2cm_pkg::CMD_WRITE) begin
               nxt.shift = tx_byte;
            end else if (cmd_sel == i2cm_pkg::CMD_READ) begin
               nxt.shift = '0;
            end
         end
      end else begin
         if (cur.tick != '0) begin
            tick_dec = cur.tick - i2cm_pkg::HALF_W'(1);
         end
         nxt.tick = tick_dec;
         if (tick_dec == '0) begin
            unique case (cur.cmd) inside
               i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: begin
                  if (cur.phase == i2cm_pkg::PHASE_FIRST) begin
                     nxt.phase = i2cm_pkg::PHASE_SECOND;
                  end else begin
                     fin = 1'b1;
                  end
               end
               i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ: begin
                  if (cur.phase == i2cm_pkg::PHASE_FIRST) begin
                     nxt.phase = i2cm_pkg::PHASE_SECOND;
                     if (cur.cmd == i2cm_pkg::CMD_READ) begin
                        nxt.shift = {cur.shift[i2cm_pkg::BYTE_W-2:0], sda_in};
                     end
                  end else begin
                     nxt.phase     = i2cm_pkg::PHASE_FIRST;
                     nxt.bit_index = bit_inc;
                     fin = (bit_inc >= i2cm_pkg::BIT_IDX_W'(i2cm_pkg::BITS_PER_BYTE));
                  end
               end
               i2cm_pkg::CMD_RACK: begin
                  nxt.ack = sda_in;
                  fin     = 1'b1;
               end
               i2cm_pkg::CMD_SACK: begin
                  if (cur.phase != i2cm_pkg::PHASE_THIRD) begin
                     nxt.phase = cur.phase + i2cm_pkg::PHASE_W'(1);
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
            load = !fin;
         end
      end

      if (load) begin
         sel = i2cm_pkg::BIT_SEL_W'(i2cm_pkg::BITS_PER_BYTE - 1)
             - nxt.bit_index[i2cm_pkg::BIT_SEL_W-1:0];
         unique case (nxt.cmd)
            i2cm_pkg::CMD_START: begin
               nxt.scl = 1'b1;
               nxt.sda = (nxt.phase == i2cm_pkg::PHASE_FIRST);
            end
            i2cm_pkg::CMD_STOP: begin
               nxt.scl = (nxt.phase != i2cm_pkg::PHASE_FIRST);
               nxt.sda = 1'b0;
            end
            i2cm_pkg::CMD_WRITE: begin
               nxt.scl = (nxt.phase != i2cm_pkg::PHASE_FIRST);
               nxt.sda = nxt.shift[sel];
            end
            i2cm_pkg::CMD_READ: begin
               nxt.scl = (nxt.phase == i2cm_pkg::PHASE_FIRST);
               nxt.sda = 1'b1;
            end
            i2cm_pkg::CMD_RACK: begin
               nxt.scl = 1'b1;
               nxt.sda = 1'b1;
            end
            i2cm_pkg::CMD_SACK: begin
               nxt.scl = (nxt.phase == i2cm_pkg::PHASE_THIRD);
               if (nxt.phase != i2cm_pkg::PHASE_FIRST) begin
                  nxt.sda = 1'b0;
               end
            end
            default: begin
               nxt.scl = cur.scl;
            end
         endcase
         nxt.tick = i2cm_pkg::seg_len(half_period);
      end

      if (fin) begin
         unique case (cur.cmd)
            i2cm_pkg::CMD_STOP: begin
               nxt.scl = 1'b1;
               nxt.sda = 1'b1;
            end
            i2cm_pkg::CMD_WRITE: begin
               nxt.scl = 1'b0;
            end
            i2cm_pkg::CMD_READ: begin
               nxt.scl = 1'b0;
               nxt.sda = 1'b1;
               nxt.rx  = nxt.shift;
            end
            default: begin
               nxt.scl = 1'b0;
               nxt.sda = 1'b0;
            end
         endcase
         nxt.cmd       = i2cm_pkg::CMD_IDLE;
         nxt.phase     = i2cm_pkg::PHASE_FIRST;
         nxt.bit_index = '0;
         nxt.tick      = '0;
         done          = 1'b1;
      end
   end

endmodule

// ===== rtl/core/i2c_master_bit_engine_unit.sv =====
// Top level of the I2C master bit engine: input register, state, result register.
// Each transaction on req_if is one bus timing tick and yields exactly one
// transaction on rsp_if. Sustained rate is one tick per clock cycle while rsp_if
// is not stalled; a tick passes the input register, then the engine state and
// result register, which update together. The result register parts the two sides,
// so a new tick is taken while a finished result waits, and a stall on rsp_if
// holds the input register. The half period (half_ff) is written through csr_we and
// csr_wdata (reset 90) and takes effect at the next SCL half-period load.
module i2c_master_bit_engine_unit (
   input  logic                          clock,
   input  logic                          reset,
   i2cm_req_if.sink                      req_if,
   i2cm_rsp_if.source                    rsp_if,
   input  logic                          csr_we,
   input  logic [i2cm_pkg::HALF_W-1:0]   csr_wdata
);

   logic                                 in_valid_ff, in_valid_in;
   logic [i2cm_pkg::OPCODE_W-1:0]        opcode_ff, opcode_in;
   logic [i2cm_pkg::BYTE_W-1:0]          tx_byte_ff, tx_byte_in;
   logic                                 sda_in_ff, sda_in_in;
   logic [i2cm_pkg::HALF_W-1:0]          half_ff, half_in;
   i2cm_pkg::engine_state_type           state_ff, state_in, state_nxt;
   logic                                 out_valid_ff, out_valid_in;
   logic                                 done_ff, done_in;
   logic                                 step_done;
   logic                                 advance;
   logic                                 accept;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   i2cm_step u_step (
      .cur         (state_ff),
      .opcode      (opcode_ff),
      .tx_byte     (tx_byte_ff),
      .sda_in      (sda_in_ff),
      .half_period (half_ff),
      .nxt         (state_nxt),
      .done        (step_done)
   );

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      opcode_in    = accept ? req_if.opcode  : opcode_ff;
      tx_byte_in   = accept ? req_if.tx_byte : tx_byte_ff;
      sda_in_in    = accept ? req_if.sda_in  : sda_in_ff;
      half_in      = csr_we ? csr_wdata : half_ff;
      state_in     = advance ? state_nxt : state_ff;
      done_in      = advance ? step_done : done_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         half_ff            <= i2cm_pkg::HALF_PERIOD_RESET;
         state_ff.cmd       <= i2cm_pkg::CMD_IDLE;
         state_ff.phase     <= i2cm_pkg::PHASE_FIRST;
         state_ff.bit_index <= '0;
         state_ff.shift     <= '0;
         state_ff.tick      <= '0;
         state_ff.scl       <= 1'b1;
         state_ff.sda       <= 1'b1;
         state_ff.ack       <= 1'b1;
         state_ff.rx        <= '0;
         done_ff            <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         half_ff      <= half_in;
         state_ff     <= state_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff  <= opcode_in;
      tx_byte_ff <= tx_byte_in;
      sda_in_ff  <= sda_in_in;
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.scl_out  = state_ff.scl;
   assign rsp_if.sda_out  = state_ff.sda;
   assign rsp_if.busy_res = (state_ff.cmd != i2cm_pkg::CMD_IDLE);
   assign rsp_if.done_res = done_ff;
   assign rsp_if.rx_byte  = state_ff.rx;
   assign rsp_if.ack_bit  = state_ff.ack;

endmodule

// ===== rtl/core/i2cm_checker.sv =====
// Port-level checks of the I2C master bit engine and their binding.
module i2cm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_scl,
   input  logic                          rsp_sda,
   input  logic                          rsp_busy,
   input  logic                          rsp_done,
   input  logic [i2cm_pkg::BYTE_W-1:0]   rsp_rx,
   input  logic                          rsp_ack
);

   logic [2:0] pending_ff, pending_in;
   logic       last_done_ff, last_done_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in   = pending_ff + 3'(req_take) - 3'(rsp_take);
      last_done_in = rsp_take ? rsp_done : last_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         last_done_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         last_done_ff <= last_done_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_sda)
         && $stable(rsp_busy) && $stable(rsp_done) && $stable(rsp_rx) && $stable(rsp_ack))
      else $error("stalled result transaction changed");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more transactions in flight than pipeline stages");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_done |-> !last_done_ff && !rsp_busy)
      else $error("done on consecutive results or while busy");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_scl   (rsp_if.scl_out),
   .rsp_sda   (rsp_if.sda_out),
   .rsp_busy  (rsp_if.busy_res),
   .rsp_done  (rsp_if.done_res),
   .rsp_rx    (rsp_if.rx_byte),
   .rsp_ack   (rsp_if.ack_bit)
);
